FILE: src/otsu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// otsu_pkg
// Shared constants, sequencer states and unit control structs.
// ----------------------------------------------------------------------------
package otsu_pkg;

    localparam int COUNT_BITS = 22;
    localparam int NUM_BINS   = 256;
    localparam int LVL_BITS   = 8;

    typedef enum logic [3:0] {
        S_CLR,
        S_IDLE,
        S_INC,
        S_RD,
        S_BIN,
        S_P,
        S_Q,
        S_D,
        S_SQ,
        S_WP,
        S_LHS,
        S_RHS,
        S_ACC,
        S_DONE
    } t_state;

    typedef struct packed {
        logic start;
    } t_mul_ctl;

    typedef struct packed {
        logic done;
    } t_mul_stat;

endpackage

FILE: src/otsu_threshold.sv
`timescale 1ns / 1ps
// Pixel transfer: busy for 1 cycle after each non-last pixel; no new pixel is taken while busy.
// Last pixel: a counting step, then a scan of all 256 levels; a level without
// a split passes RD, BIN and ACC, otherwise also P, Q, D, SQ, WP, LHS and RHS, paced
// by the shared shift-add multiplier; o_valid then pulses once, the receiver cannot stall.
// Reset (sync, active low): histogram clearing pass over all 256 bins, busy meanwhile.
// ----------------------------------------------------------------------------
// otsu_threshold
// Otsu threshold of an 8-bit image: histogram counting, then an exact
// integer scan of all levels with a single shared multiplier.
// ----------------------------------------------------------------------------
module otsu_threshold #(
    parameter int COUNT_BITS = otsu_pkg::COUNT_BITS
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [7:0] i_pixel,
    input  logic       i_last_pixel,
    output logic       o_valid,
    output logic [7:0] o_threshold
);

    localparam int LB   = otsu_pkg::LVL_BITS;
    localparam int TW   = COUNT_BITS + 1;       // pixel count / bin
    localparam int SW   = COUNT_BITS + 9;       // gray-level sums
    localparam int DW   = SW + TW;              // sumB*total, difference
    localparam int SQW  = 2 * DW;               // squared difference
    localparam int WPW  = 2 * TW;               // weight product
    localparam int PW   = SQW + DW;             // multiplier output

    otsu_pkg::t_state    r_state, n_state;
    otsu_pkg::t_mul_ctl  mul_ctl;
    otsu_pkg::t_mul_stat mul_stat;

    logic [LB-1:0]  r_lvl;
    logic [LB-1:0]  r_pix;
    logic           r_last;
    logic           r_issued;
    logic [TW-1:0]  r_total;
    logic [SW-1:0]  r_wsum;
    logic [TW-1:0]  r_wb;
    logic [SW-1:0]  r_sumb;
    logic [TW-1:0]  r_bin;
    logic [DW-1:0]  r_p;
    logic [DW-1:0]  r_q;
    logic [SQW-1:0] r_sq;
    logic [WPW-1:0] r_wp;
    logic [PW-1:0]  r_lhs;
    logic [SQW-1:0] r_bs;
    logic [WPW-1:0] r_bw;
    logic [LB-1:0]  r_best;

    logic           accept;
    logic           mul_state;
    logic [TW-1:0]  wf;
    logic           split;
    logic [TW+LB-1:0] lvl_bin;
    logic [SQW-1:0] mul_a;
    logic [DW-1:0]  mul_b;
    logic [PW-1:0]  mul_prod;

    logic           h_we;
    logic [LB-1:0]  h_waddr;
    logic [TW-1:0]  h_wdata;
    logic [LB-1:0]  h_raddr;
    logic [TW-1:0]  h_rdata;

    assign accept  = start && (r_state == otsu_pkg::S_IDLE);
    assign wf      = r_total - r_wb;
    assign split   = (r_wb != '0) && (wf != '0);
    assign lvl_bin = r_lvl * r_bin;

    always_comb begin
        case (r_state) inside
            otsu_pkg::S_P, otsu_pkg::S_Q, otsu_pkg::S_SQ,
            otsu_pkg::S_WP, otsu_pkg::S_LHS, otsu_pkg::S_RHS: mul_state = 1'b1;
            default: mul_state = 1'b0;
        endcase
    end

    assign mul_ctl.start = mul_state && !r_issued;

    // operand select for the shared multiplier
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            otsu_pkg::S_P: begin
                mul_a = SQW'(r_sumb);
                mul_b = DW'(r_total);
            end
            otsu_pkg::S_Q: begin
                mul_a = SQW'(r_wsum);
                mul_b = DW'(r_wb);
            end
            otsu_pkg::S_SQ: begin
                mul_a = SQW'(r_p);
                mul_b = r_p;
            end
            otsu_pkg::S_WP: begin
                mul_a = SQW'(r_wb);
                mul_b = DW'(wf);
            end
            otsu_pkg::S_LHS: begin
                mul_a = r_sq;
                mul_b = DW'(r_bw);
            end
            otsu_pkg::S_RHS: begin
                mul_a = r_bs;
                mul_b = DW'(r_wp);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    otsu_mul #(
        .A_W (SQW),
        .B_W (DW)
    ) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (mul_ctl),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_stat  (mul_stat),
        .o_prod  (mul_prod)
    );

    // histogram ports: counting increments, clearing pass and scan write zero
    always_comb begin
        h_raddr = (r_state == otsu_pkg::S_IDLE) ? i_pixel : r_lvl;
        h_we    = 1'b0;
        h_waddr = r_lvl;
        h_wdata = '0;
        case (r_state)
            otsu_pkg::S_CLR: h_we = 1'b1;
            otsu_pkg::S_BIN: h_we = 1'b1;
            otsu_pkg::S_INC: begin
                h_we    = !r_total[TW-1];
                h_waddr = r_pix;
                h_wdata = h_rdata + TW'(1);
            end
            default: h_we = 1'b0;
        endcase
    end

    otsu_hist #(
        .DATA_W (TW)
    ) u_hist (
        .i_clk   (i_clk),
        .i_we    (h_we),
        .i_waddr (h_waddr),
        .i_wdata (h_wdata),
        .i_raddr (h_raddr),
        .o_rdata (h_rdata)
    );

    // sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            otsu_pkg::S_CLR:  if (r_lvl == LB'(otsu_pkg::NUM_BINS - 1)) n_state = otsu_pkg::S_IDLE;
            otsu_pkg::S_IDLE: if (start) n_state = otsu_pkg::S_INC;
            otsu_pkg::S_INC:  n_state = r_last ? otsu_pkg::S_RD : otsu_pkg::S_IDLE;
            otsu_pkg::S_RD:   n_state = otsu_pkg::S_BIN;
            otsu_pkg::S_BIN:  n_state = split ? otsu_pkg::S_P : otsu_pkg::S_ACC;
            otsu_pkg::S_P:    if (mul_stat.done) n_state = otsu_pkg::S_Q;
            otsu_pkg::S_Q:    if (mul_stat.done) n_state = otsu_pkg::S_D;
            otsu_pkg::S_D:    n_state = otsu_pkg::S_SQ;
            otsu_pkg::S_SQ:   if (mul_stat.done) n_state = otsu_pkg::S_WP;
            otsu_pkg::S_WP:   if (mul_stat.done) n_state = otsu_pkg::S_LHS;
            otsu_pkg::S_LHS:  if (mul_stat.done) n_state = otsu_pkg::S_RHS;
            otsu_pkg::S_RHS:  if (mul_stat.done) n_state = otsu_pkg::S_ACC;
            otsu_pkg::S_ACC:  begin
                n_state = (r_lvl == LB'(otsu_pkg::NUM_BINS - 1)) ? otsu_pkg::S_DONE
                                                                : otsu_pkg::S_RD;
            end
            otsu_pkg::S_DONE: n_state = otsu_pkg::S_IDLE;
            default:          n_state = otsu_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= otsu_pkg::S_CLR;
            r_lvl    <= '0;
            r_issued <= 1'b0;
            r_total  <= '0;
            r_wsum   <= '0;
        end else begin
            r_state <= n_state;
            if (mul_stat.done) begin
                r_issued <= 1'b0;
            end else if (mul_ctl.start) begin
                r_issued <= 1'b1;
            end
            case (r_state)
                otsu_pkg::S_CLR: r_lvl <= r_lvl + LB'(1);
                otsu_pkg::S_INC: begin
                    if (!r_total[TW-1]) begin
                        r_total <= r_total + TW'(1);
                        r_wsum  <= r_wsum + SW'(r_pix);
                    end
                    r_lvl <= '0;
                end
                otsu_pkg::S_ACC: r_lvl <= r_lvl + LB'(1);
                otsu_pkg::S_DONE: begin
                    r_total <= '0;
                    r_wsum  <= '0;
                end
                default: r_lvl <= r_lvl;
            endcase
        end
    end

    // scan datapath
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_pix  <= i_pixel;
            r_last <= i_last_pixel;
            r_wb   <= '0;
            r_sumb <= '0;
            r_best <= '0;
            r_bs   <= '0;
            r_bw   <= WPW'(1);
        end
        case (r_state)
            otsu_pkg::S_BIN: r_bin <= h_rdata;
            otsu_pkg::S_P:   if (mul_stat.done) r_p <= mul_prod[DW-1:0];
            otsu_pkg::S_Q:   if (mul_stat.done) r_q <= mul_prod[DW-1:0];
            otsu_pkg::S_D:   r_p <= (r_p >= r_q) ? (r_p - r_q) : (r_q - r_p);
            otsu_pkg::S_SQ:  if (mul_stat.done) r_sq <= mul_prod[SQW-1:0];
            otsu_pkg::S_WP:  if (mul_stat.done) r_wp <= mul_prod[WPW-1:0];
            otsu_pkg::S_LHS: if (mul_stat.done) r_lhs <= mul_prod;
            otsu_pkg::S_RHS: begin
                // equal score: later level wins
                if (mul_stat.done && (r_lhs >= mul_prod)) begin
                    r_best <= r_lvl;
                    r_bs   <= r_sq;
                    r_bw   <= r_wp;
                end
            end
            otsu_pkg::S_ACC: begin
                r_wb   <= r_wb + r_bin;
                r_sumb <= r_sumb + SW'(lvl_bin);
            end
            default: r_bin <= r_bin;
        endcase
    end

    assign busy        = (r_state != otsu_pkg::S_IDLE);
    assign o_valid     = (r_state == otsu_pkg::S_DONE);
    assign o_threshold = r_best;

endmodule

FILE: src/otsu_hist.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// otsu_hist
// Histogram store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module otsu_hist #(
    parameter int DATA_W = otsu_pkg::COUNT_BITS + 1
) (
    input  logic                          i_clk,
    input  logic                          i_we,
    input  logic [otsu_pkg::LVL_BITS-1:0] i_waddr,
    input  logic [DATA_W-1:0]             i_wdata,
    input  logic [otsu_pkg::LVL_BITS-1:0] i_raddr,
    output logic [DATA_W-1:0]             o_rdata
);

    logic [DATA_W-1:0] r_mem [otsu_pkg::NUM_BINS];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: src/otsu_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// otsu_mul
// Shift-add multiplier, one multiplier bit per cycle, stops early once the
// remaining multiplier bits are zero.
// ----------------------------------------------------------------------------
module otsu_mul #(
    parameter int A_W = 108,
    parameter int B_W = 54
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  otsu_pkg::t_mul_ctl   i_ctl,
    input  logic [A_W-1:0]       i_a,
    input  logic [B_W-1:0]       i_b,
    output otsu_pkg::t_mul_stat  o_stat,
    output logic [A_W+B_W-1:0]   o_prod
);

    localparam int P_W = A_W + B_W;

    logic             r_run;
    logic [P_W-1:0]   r_a;
    logic [B_W-1:0]   r_b;
    logic [P_W-1:0]   r_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= 1'b0;
        end else if (i_ctl.start) begin
            r_run <= 1'b1;
        end else if (r_run && (r_b == '0)) begin
            r_run <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_a   <= P_W'(i_a);
            r_b   <= i_b;
            r_acc <= '0;
        end else if (r_run && (r_b != '0)) begin
            if (r_b[0]) begin
                r_acc <= r_acc + r_a;
            end
            r_a <= {r_a[P_W-2:0], 1'b0};
            r_b <= {1'b0, r_b[B_W-1:1]};
        end
    end

    assign o_stat.done = r_run && (r_b == '0);
    assign o_prod      = r_acc;

endmodule

FILE: src/otsu_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// otsu_chk
// Port-level checks on the transfer timing of otsu_threshold.
// ----------------------------------------------------------------------------
module otsu_chk (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       start,
    input logic       busy,
    input logic [7:0] i_pixel,
    input logic       i_last_pixel,
    input logic       o_valid,
    input logic [7:0] o_threshold
);

    // clearing pass keeps the block busy straight after reset
    a_rst_busy: assert property (@(posedge i_clk) !i_rst_n |=> busy)
        else $error("not busy after reset");

    a_pix_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && !i_last_pixel) |=> busy ##1 !busy)
        else $error("non-last pixel transfer not one busy cycle");

    a_no_early: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> !o_valid)
        else $error("result too early");

    a_valid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (!$isunknown(o_threshold) && busy) ##1 (!o_valid && !busy))
        else $error("result strobe malformed");

    a_pix_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> !$isunknown({i_pixel, i_last_pixel}))
        else $error("unknown pixel on transfer");

endmodule

bind otsu_threshold otsu_chk u_otsu_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .start        (start),
    .busy         (busy),
    .i_pixel      (i_pixel),
    .i_last_pixel (i_last_pixel),
    .o_valid      (o_valid),
    .o_threshold  (o_threshold)
);

FILE: sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Streams gray images into otsu_threshold and checks each chosen level
// against a histogram-based Otsu predictor with exact wide arithmetic.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int CB         = otsu_pkg::COUNT_BITS;
    localparam int IMG_LIMIT  = 1 << CB;
    localparam int N_PIXELS   = 1250;
    localparam int WD_LIMIT   = 400000;
    localparam int TAIL_WAIT  = 400;

    logic       i_clk;
    logic       i_rst_n;
    logic       start;
    logic       busy;
    logic [7:0] i_pixel;
    logic       i_last_pixel;
    logic       o_valid;
    logic [7:0] o_threshold;

    otsu_threshold #(
        .COUNT_BITS(CB)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_pixel     (i_pixel),
        .i_last_pixel(i_last_pixel),
        .o_valid     (o_valid),
        .o_threshold (o_threshold)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // Predictor state: mirror of the histogram
    int unsigned      hist[otsu_pkg::NUM_BINS];
    longint unsigned  pix_total;
    longint unsigned  level_sum;
    logic [7:0]       level_q[$];

    int  n_mismatch;
    int  n_results;
    int  n_images;
    int  n_pixels;
    bit  idle_on;
    int  wd_count;

    // Otsu scan over the current histogram; 256-bit values hold every product
    // without wrapping
    function automatic logic [7:0] otsu_level();
        logic [255:0] wb, sumb, wf, tot, wsum, p, q, d, sq, wp, lhs, rhs;
        logic [255:0] b_score, b_weight;
        logic [7:0]   best;
        best     = '0;
        b_score  = '0;
        b_weight = 256'd1;
        wb       = '0;
        sumb     = '0;
        tot      = 256'(pix_total);
        wsum     = 256'(level_sum);
        for (int lvl = 0; lvl < otsu_pkg::NUM_BINS; lvl++) begin
            wf = tot - wb;
            if (wb != 0 && wf != 0) begin
                // sumB*wF - sumF*wB rewritten as sumB*total - wsum*wB
                p   = sumb * tot;
                q   = wsum * wb;
                d   = (p >= q) ? p - q : q - p;
                sq  = d * d;
                wp  = wb * wf;
                lhs = sq * b_weight;
                rhs = b_score * wp;
                if (lhs >= rhs) begin   // ties go to the later level
                    best     = 8'(lvl);
                    b_score  = sq;
                    b_weight = wp;
                end
            end
            wb   = wb + 256'(hist[lvl]);
            sumb = sumb + 256'(lvl) * 256'(hist[lvl]);
        end
        return best;
    endfunction

    function automatic void clear_image();
        foreach (hist[k]) hist[k] = 0;
        pix_total = 0;
        level_sum = 0;
    endfunction

    // One accepted pixel transfer into the predictor
    function automatic void count_pixel(logic [7:0] pix, logic last);
        if (pix_total < IMG_LIMIT) begin   // beyond the limit pixels are dropped
            hist[pix]++;
            pix_total++;
            level_sum += pix;
        end
        if (last) begin
            level_q.push_back(otsu_level());
            clear_image();
            n_images++;
        end
    endfunction

    // Drive one pixel at the falling edge and hold it until busy is low
    task automatic send_pixel(logic [7:0] pix, logic last);
        @(negedge i_clk);
        start        = 1'b1;
        i_pixel      = pix;
        i_last_pixel = last;
        do @(posedge i_clk); while (busy);
        count_pixel(pix, last);
        n_pixels++;
        if (idle_on && $urandom_range(0, 99) < 18) begin
            @(negedge i_clk);
            start = 1'b0;
            repeat ($urandom_range(0, 3)) @(negedge i_clk);
        end
    endtask

    task automatic lower_start();
        @(negedge i_clk);
        start = 1'b0;
    endtask

    // ---- directed tests ----
    task automatic test_single_pixel();
        send_pixel(8'd255, 1'b1);      // one pixel: no split
        send_pixel(8'd0, 1'b1);
    endtask

    task automatic test_flat_image();
        repeat (4) send_pixel(8'd128, 1'b0);
        send_pixel(8'd128, 1'b1);      // one level only: threshold 0
    endtask

    task automatic test_extremes();
        send_pixel(8'd0, 1'b0);
        send_pixel(8'd255, 1'b0);
        send_pixel(8'd0, 1'b0);
        send_pixel(8'd255, 1'b1);
        send_pixel(8'd1, 1'b0);
        send_pixel(8'd254, 1'b0);
        send_pixel(8'd127, 1'b1);
    endtask

    task automatic test_ties();
        // every level from 11 to 20 scores the same; the last one wins
        send_pixel(8'd10, 1'b0);
        send_pixel(8'd20, 1'b0);
        send_pixel(8'd10, 1'b0);
        send_pixel(8'd20, 1'b1);
    endtask

    // Sender holds off until every outstanding level has come back
    task automatic test_drain_pause();
        lower_start();
        while (level_q.size() != 0) @(posedge i_clk);
        send_pixel(8'd64, 1'b0);
        send_pixel(8'd192, 1'b1);
    endtask

    task automatic send_image(int len, int base, int span);
        int v;
        for (int k = 0; k < len; k++) begin
            v = base + $urandom_range(0, span);
            if (v > 255) v = 255;
            send_pixel(8'(v), k == len - 1);
        end
    endtask

    task automatic test_random_images();
        int len, base, span;
        while (n_pixels < N_PIXELS) begin
            // quiet stretch with no idling in the middle of the run
            idle_on = !(n_images >= 20 && n_images < 30);
            len  = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 30);
            base = $urandom_range(0, 255);
            span = $urandom_range(0, 7);
            if ($urandom_range(0, 9) == 0) begin   // full-range image, slow scan
                base = 0;
                span = 255;
            end
            send_image(len, base, span);
        end
        idle_on = 1'b1;
    endtask

    // Result checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            n_results++;
            if (level_q.size() == 0) begin
                n_mismatch++;
                if (n_mismatch <= 10)
                    $display("unexpected threshold %0d", o_threshold);
            end else begin
                logic [7:0] exp_lvl;
                exp_lvl = level_q.pop_front();
                if (o_threshold !== exp_lvl) begin
                    n_mismatch++;
                    if (n_mismatch <= 10)
                        $display("threshold mismatch: expected %0d got %0d",
                                 exp_lvl, o_threshold);
                end
            end
        end
    end

    // Watchdog: cycles with no transfer in either direction
    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid)
            wd_count <= 0;
        else
            wd_count <= wd_count + 1;
        if (wd_count >= WD_LIMIT) begin
            $display("watchdog expired");
            $display("otsu_threshold test failed");
            $finish;
        end
    end

    initial begin
        i_rst_n      = 1'b0;
        start        = 1'b0;
        i_pixel      = '0;
        i_last_pixel = 1'b0;
        n_mismatch   = 0;
        n_results    = 0;
        n_images     = 0;
        n_pixels     = 0;
        wd_count     = 0;
        idle_on      = 1'b1;
        clear_image();
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_single_pixel();
        test_flat_image();
        test_extremes();
        test_ties();
        test_drain_pause();
        test_random_images();
        lower_start();

        while (level_q.size() != 0) @(posedge i_clk);
        repeat (TAIL_WAIT) @(posedge i_clk);

        $display("covered %0d images, %0d pixels, %0d levels checked",
                 n_images, n_pixels, n_results);
        $display("incl. flat, extreme, tie and full-range images; %0d mismatches",
                 n_mismatch);
        if (n_mismatch == 0 && level_q.size() == 0)
            $display("otsu_threshold test passed");
        else
            $display("otsu_threshold test failed");
        $finish;
    end

endmodule
